/* sv/char_stream_token_classifier_defines.svh */
// ----------------------------------------------------------------------------
// Character stream token classifier: assertion macros
// Shared concurrent assertion forms for the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef CHAR_STREAM_TOKEN_CLASSIFIER_DEFINES_SVH
`define CHAR_STREAM_TOKEN_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cstc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CSTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cstc: next-cycle check failed");

`endif

/* sv/cstc_pkg.sv */
// ----------------------------------------------------------------------------
// Character stream token classifier package
// Byte and class types, token class codes, keyword indices, the digit test and the operator character test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cstc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_class;

    localparam int    LEN_W         = 8;
    localparam int    WIN_DEPTH     = 5;
    localparam logic [LEN_W-1:0] MAX_TOKEN_LEN = 8'd255;

    localparam t_class CLS_NUMBER = 4'd0;
    localparam t_class CLS_IF     = 4'd1;
    localparam t_class CLS_ELSE   = 4'd2;
    localparam t_class CLS_WHILE  = 4'd3;
    localparam t_class CLS_DO     = 4'd4;
    localparam t_class CLS_FOR    = 4'd5;
    localparam t_class CLS_SWITCH = 4'd6;
    localparam t_class CLS_CASE   = 4'd7;
    localparam t_class CLS_ID     = 4'd8;
    localparam t_class CLS_OPR    = 4'd9;

    localparam int KW_IF     = 0;
    localparam int KW_ELSE   = 1;
    localparam int KW_WHILE  = 2;
    localparam int KW_DO     = 3;
    localparam int KW_FOR    = 4;
    localparam int KW_SWITCH = 5;
    localparam int KW_CASE   = 6;
    localparam int KW_COUNT  = 7;

    function automatic logic is_opr(input t_byte c);
        logic hit;
        hit = (c == ">") || (c == "<") || (c == "=") || (c == "+") ||
              (c == "-") || (c == "/") || (c == "*") || (c == "!") ||
              (c == "(") || (c == ")") || (c == "{") || (c == "}");
        return hit;
    endfunction

    function automatic logic is_digit(input t_byte c);
        return (c >= "0") && (c <= "9");
    endfunction

endpackage

`default_nettype wire

/* sv/char_stream_token_classifier.sv */
// ----------------------------------------------------------------------------
// Character stream token classifier
// Splits a byte stream into operator and non-operator runs and classes each
// token as number, keyword, identifier or operator.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one character per transfer, with the character
// that follows it and a last-character flag. The output channel returns one
// transfer per input transfer: the character echoed, a token-end flag and,
// on token end, the token class and length (saturating at 255).
// An input transfer's result is registered and shown in the next cycle.
// Throughput is one character per clock while the output is not stalled; the
// per-token state (a five-byte window, a digit flag, seven keyword flags
// and a run length) is updated in the same cycle as the character is taken.
// The result sits in an output register. When the receiver stalls, that
// register holds its result and the input is held off until the result is
// taken; a transfer on the output in the same cycle frees the register for
// the next character.
// Reset clears the token state and empties the output register; the block
// is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_stream_token_classifier (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire cstc_pkg::t_byte i_ch,
    input  wire cstc_pkg::t_byte i_next_ch,
    input  wire logic            i_is_last,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output cstc_pkg::t_byte      o_echo_ch,
    output logic                 o_token_end,
    output cstc_pkg::t_class     o_token_class,
    output logic [7:0]           o_token_length
);

    import cstc_pkg::*;

    `include "char_stream_token_classifier_defines.svh"

    t_byte              r_win [WIN_DEPTH];
    logic               r_digit_seen;
    logic [KW_COUNT-1:0] r_kw_seen;
    logic [LEN_W-1:0]   r_run_len;
    logic               r_out_valid;
    t_byte              r_echo_ch;
    logic               r_token_end;
    t_class             r_token_class;
    logic [7:0]         r_token_length;

    logic                accept;
    logic                c_opr;
    logic                tok_end;
    logic                n_digit_seen;
    logic [KW_COUNT-1:0] n_kw_seen;
    logic [LEN_W-1:0]    n_run_len;
    t_class              cls;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        c_opr   = is_opr(i_ch);
        tok_end = i_is_last || (c_opr != is_opr(i_next_ch));

        n_digit_seen = r_digit_seen || is_digit(i_ch);

        n_kw_seen = r_kw_seen;
        if (r_win[4] == "i" && i_ch == "f") begin
            n_kw_seen[KW_IF] = 1'b1;
        end
        if (r_win[2] == "e" && r_win[3] == "l" && r_win[4] == "s" && i_ch == "e") begin
            n_kw_seen[KW_ELSE] = 1'b1;
        end
        if (r_win[1] == "w" && r_win[2] == "h" && r_win[3] == "i" && r_win[4] == "l" &&
            i_ch == "e") begin
            n_kw_seen[KW_WHILE] = 1'b1;
        end
        if (r_win[4] == "d" && i_ch == "o") begin
            n_kw_seen[KW_DO] = 1'b1;
        end
        if (r_win[3] == "f" && r_win[4] == "o" && i_ch == "r") begin
            n_kw_seen[KW_FOR] = 1'b1;
        end
        if (r_win[0] == "s" && r_win[1] == "w" && r_win[2] == "i" && r_win[3] == "t" &&
            r_win[4] == "c" && i_ch == "h") begin
            n_kw_seen[KW_SWITCH] = 1'b1;
        end
        if (r_win[2] == "c" && r_win[3] == "a" && r_win[4] == "s" && i_ch == "e") begin
            n_kw_seen[KW_CASE] = 1'b1;
        end

        n_run_len = (r_run_len < MAX_TOKEN_LEN) ? r_run_len + 1'b1 : r_run_len;

        if (c_opr) begin
            cls = CLS_OPR;
        end else if (n_digit_seen) begin
            cls = CLS_NUMBER;
        end else if (n_kw_seen[KW_IF]) begin
            cls = CLS_IF;
        end else if (n_kw_seen[KW_ELSE]) begin
            cls = CLS_ELSE;
        end else if (n_kw_seen[KW_WHILE]) begin
            cls = CLS_WHILE;
        end else if (n_kw_seen[KW_DO]) begin
            cls = CLS_DO;
        end else if (n_kw_seen[KW_FOR]) begin
            cls = CLS_FOR;
        end else if (n_kw_seen[KW_SWITCH]) begin
            cls = CLS_SWITCH;
        end else if (n_kw_seen[KW_CASE]) begin
            cls = CLS_CASE;
        end else begin
            cls = CLS_ID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
            r_digit_seen <= 1'b0;
            r_kw_seen    <= '0;
            r_run_len    <= '0;
        end else if (accept) begin
            if (tok_end) begin
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    r_win[i] <= '0;
                end
                r_digit_seen <= 1'b0;
                r_kw_seen    <= '0;
                r_run_len    <= '0;
            end else begin
                for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WIN_DEPTH-1] <= i_ch;
                r_digit_seen       <= n_digit_seen;
                r_kw_seen          <= n_kw_seen;
                r_run_len          <= n_run_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_echo_ch      <= i_ch;
            r_token_end    <= tok_end;
            r_token_class  <= tok_end ? cls : CLS_NUMBER;
            r_token_length <= tok_end ? n_run_len[7:0] : 8'd0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_echo_ch      = r_echo_ch;
    assign o_token_end    = r_token_end;
    assign o_token_class  = r_token_class;
    assign o_token_length = r_token_length;

    `CSTC_ASSERT_NOW(a_end_has_length, i_clk, i_rst_n,
        o_valid && o_token_end, o_token_length != 8'd0)
    `CSTC_ASSERT_NOW(a_open_fields_zero, i_clk, i_rst_n,
        o_valid && !o_token_end, o_token_class == CLS_NUMBER && o_token_length == 8'd0)
    `CSTC_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n,
        accept && i_is_last, r_run_len == '0 && !r_digit_seen && r_kw_seen == '0)

endmodule

`default_nettype wire
